FILE: rtl/sorted_list_merger_macros.svh
`ifndef SORTED_LIST_MERGER_MACROS_SVH
`define SORTED_LIST_MERGER_MACROS_SVH

// Same-cycle implication, checked on clk with the reset held off.
`define SLM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk with the reset held off.
`define SLM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/slm_pkg.sv
package slm_pkg;

	localparam int FIFO_DEPTH = 32;
	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_SELECT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 2'd1;

	typedef struct packed {
		logic        from_second;
		logic [31:0] doc_id;
		logic [31:0] score;
		logic        last_of_list;
	} item_t;

	typedef struct packed {
		logic key_select;
		logic descending;
	} cfg_t;

	typedef struct packed {
		logic [31:0] doc_id;
		logic [31:0] score;
		logic        came_from_second;
		logic        run_last;
		logic        overflow;
	} result_t;

endpackage

FILE: rtl/slm_front.sv
module slm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  slm_pkg::item_t in_item,
	output logic          q_valid,
	output slm_pkg::item_t q_item,
	input  logic          q_take
);
	import slm_pkg::*;

	item_t      entries_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_take && q_valid;
	assign q_item   = entries_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= in_item;
		end
	end

endmodule

FILE: rtl/slm_back.sv
`include "sorted_list_merger_macros.svh"

module slm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  slm_pkg::cfg_t    cfg,
	input  logic             q_valid,
	input  slm_pkg::item_t   q_item,
	output logic             q_take,
	output logic             res_valid,
	input  logic             res_stall,
	output slm_pkg::result_t res
);
	import slm_pkg::*;

	typedef enum logic [2:0] {
		ST_TAKE = 3'b001,
		ST_READ = 3'b010,
		ST_PICK = 3'b100
	} state_t;

	state_t           state_q;
	logic [PTR_W-1:0] head_q [2];
	logic [PTR_W-1:0] tail_q [2];
	logic [CNT_W-1:0] count_q [2];
	logic             ended_q [2];
	logic [63:0]      mem0 [FIFO_DEPTH];
	logic [63:0]      mem1 [FIFO_DEPTH];
	logic [63:0]      rdata_q [2];
	logic             res_valid_q;
	result_t          res_q;

	logic        out_free;
	logic        sel;
	logic        is_full;
	logic        take_push;
	logic        take_ovf;
	logic        has0;
	logic        has1;
	logic        can_pick;
	logic        pick_fire;
	logic        src;
	logic        second_wins;
	logic [31:0] key0;
	logic [31:0] key1;
	logic [63:0] head_data;
	logic        run_done;

	assign out_free  = !res_valid_q || !res_stall;
	assign sel       = q_item.from_second;
	assign is_full   = (count_q[sel] == CNT_W'(FIFO_DEPTH));
	assign take_ovf  = (state_q == ST_TAKE) && q_valid && is_full && out_free;
	assign take_push = (state_q == ST_TAKE) && q_valid && !is_full && !ended_q[sel];
	assign q_take    = (state_q == ST_TAKE) && q_valid && (!is_full || out_free);

	assign key0        = cfg.key_select ? rdata_q[0][31:0] : rdata_q[0][63:32];
	assign key1        = cfg.key_select ? rdata_q[1][31:0] : rdata_q[1][63:32];
	assign second_wins = cfg.descending ? (key1 > key0) : (key1 < key0);
	assign has0        = (count_q[0] != '0);
	assign has1        = (count_q[1] != '0);

	always_comb begin
		can_pick = 1'b0;
		src      = 1'b0;
		priority if (has0 && has1) begin
			can_pick = 1'b1;
			src      = second_wins;
		end else if (has0 && ended_q[1]) begin
			can_pick = 1'b1;
			src      = 1'b0;
		end else if (has1 && ended_q[0]) begin
			can_pick = 1'b1;
			src      = 1'b1;
		end else begin
			can_pick = 1'b0;
			src      = 1'b0;
		end
	end

	assign pick_fire = (state_q == ST_PICK) && can_pick && out_free;
	assign head_data = src ? rdata_q[1] : rdata_q[0];
	assign run_done  = ended_q[0] && ended_q[1] && (count_q[src] == CNT_W'(1))
		&& (count_q[~src] == '0);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_TAKE;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
				ended_q[i] <= 1'b0;
			end
		end else begin
			if (take_ovf || pick_fire) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_TAKE: begin
					if (take_push) begin
						tail_q[sel]  <= ptr_inc(tail_q[sel]);
						count_q[sel] <= count_q[sel] + CNT_W'(1);
						if (q_item.last_of_list) begin
							ended_q[sel] <= 1'b1;
						end
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_PICK;
				end
				ST_PICK: begin
					if (!can_pick) begin
						state_q <= ST_TAKE;
					end else if (pick_fire) begin
						head_q[src]  <= ptr_inc(head_q[src]);
						count_q[src] <= count_q[src] - CNT_W'(1);
						if (run_done) begin
							ended_q[0] <= 1'b0;
							ended_q[1] <= 1'b0;
						end
						state_q <= ST_READ;
					end
				end
				default: state_q <= ST_TAKE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_push && !sel) begin
			mem0[tail_q[0]] <= {q_item.doc_id, q_item.score};
		end
		if (take_push && sel) begin
			mem1[tail_q[1]] <= {q_item.doc_id, q_item.score};
		end
		rdata_q[0] <= mem0[head_q[0]];
		rdata_q[1] <= mem1[head_q[1]];
	end

	always_ff @(posedge clk) begin
		if (take_ovf) begin
			res_q <= '{doc_id: '0, score: '0, came_from_second: 1'b0,
				run_last: 1'b0, overflow: 1'b1};
		end else if (pick_fire) begin
			res_q <= '{doc_id: head_data[63:32], score: head_data[31:0],
				came_from_second: src, run_last: run_done, overflow: 1'b0};
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`SLM_ASSERT_NOW(a_count_bound, 1'b1,
		(count_q[0] <= CNT_W'(FIFO_DEPTH)) && (count_q[1] <= CNT_W'(FIFO_DEPTH)),
		"list FIFO count beyond depth")
	`SLM_ASSERT_NOW(a_pop_nonempty, pick_fire, count_q[src] != '0,
		"pop from an empty list FIFO")
	`SLM_ASSERT_NEXT(a_run_clears, pick_fire && run_done, !ended_q[0] && !ended_q[1],
		"end marks not cleared after run completion")

endmodule

FILE: rtl/sorted_list_merger.sv
// Two-way merge of sorted (document id, score) lists. Entries of both lists
// enter through a two-item input queue and are merged by a back end that keeps
// one memory-based FIFO per list. A stored entry goes through the back-end
// states in order: ST_TAKE stores it, ST_READ does the registered read of the
// list memory heads and ST_PICK compares them. Each merged entry it releases
// adds a fresh head read and a compare, while the output is not stalled. A
// refused entry (full FIFO) yields an overflow result, and one that arrives
// after its list has ended is dropped; neither leaves ST_TAKE.
module sorted_list_merger (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           from_second,
	input  logic [31:0]                    doc_id,
	input  logic [31:0]                    score,
	input  logic                           last_of_list,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [31:0]                    out_doc_id,
	output logic [31:0]                    out_score,
	output logic                           came_from_second,
	output logic                           run_last,
	output logic                           overflow,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [slm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic                           cfg_data
);
	import slm_pkg::*;

	cfg_t    cfg_q;
	item_t   in_item;
	item_t   q_item;
	logic    q_valid;
	logic    q_take;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY_SELECT: cfg_q.key_select <= cfg_data;
				CFG_DESCENDING: cfg_q.descending <= cfg_data;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	assign in_item = '{from_second: from_second, doc_id: doc_id, score: score,
		last_of_list: last_of_list};

	slm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_take   (q_take)
	);

	slm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_take    (q_take),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.res       (res)
	);

	assign out_doc_id       = res.doc_id;
	assign out_score        = res.score;
	assign came_from_second = res.came_from_second;
	assign run_last         = res.run_last;
	assign overflow         = res.overflow;

endmodule
